// ===== rtl/core/mrx_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the Modbus RTU receiver.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package mrx_pkg;

  localparam int BUF_BYTES = 256;                     // bytes kept per frame
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);   // frame byte counter
  localparam int QDEPTH    = 4;                       // command queue, power of two
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  MAX_PDU_RESET = 8'd252;

  // input request kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // queue command ops
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // byte position classes within a frame
  localparam logic [1:0] POS_ADDR = 2'd0;
  localparam logic [1:0] POS_FUNC = 2'd1;
  localparam logic [1:0] POS_HOLD = 2'd2;  // third and fourth byte
  localparam logic [1:0] POS_DATA = 2'd3;  // fifth byte onward

  // result kinds
  localparam logic [1:0] RK_DATA   = 2'd0;
  localparam logic [1:0] RK_GOOD   = 2'd1;
  localparam logic [1:0] RK_BADCRC = 2'd2;
  localparam logic [1:0] RK_TOOBIG = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [1:0] pos;
    logic       report;  // end of a frame of four bytes or more
    logic [7:0] len;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrx_front.sv =====
// Front end: accepts requests, tracks frame position and turns each request,
// but for bytes past the buffer, into a queue command. Depends on mrx_pkg.
`default_nettype none

module mrx_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_byte,
  input  wire logic        q_full,
  output logic             push,
  output mrx_pkg::cmd_t    cmd
);
  import mrx_pkg::*;

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic             accept;
  logic             buf_full;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign buf_full = (byte_count >= CNT_W'(BUF_BYTES));

  // bytes past the buffer are swallowed without a command
  assign push = accept && !((in_kind == KIND_BYTE) && buf_full);

  always_comb begin
    cmd.op     = (in_kind == KIND_TIMEOUT) ? OP_END : OP_BYTE;
    cmd.data   = in_byte;
    cmd.report = (byte_count >= CNT_W'(4));
    cmd.len    = 8'(byte_count - CNT_W'(4));
    if (byte_count == CNT_W'(0)) begin
      cmd.pos = POS_ADDR;
    end else if (byte_count == CNT_W'(1)) begin
      cmd.pos = POS_FUNC;
    end else if (byte_count < CNT_W'(4)) begin
      cmd.pos = POS_HOLD;
    end else begin
      cmd.pos = POS_DATA;
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    if (accept) begin
      if (in_kind == KIND_TIMEOUT) begin
        byte_count_next = '0;
      end else if (!buf_full) begin
        byte_count_next = byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mrx_queue.sv =====
// Short command queue between the front end and the frame engine.
// Depends on mrx_pkg.
`default_nettype none

module mrx_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mrx_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output mrx_pkg::cmd_t       head,
  output mrx_pkg::qstat_t     stat
);
  import mrx_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mrx_back.sv =====
// Frame engine: runs the CRC, holds back the last two bytes, decides the
// frame status and owns the output register. Depends on mrx_pkg.
`default_nettype none

module mrx_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_wdata,
  input  wire logic           q_empty,
  input  wire mrx_pkg::cmd_t  cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_kind,
  output logic [31:0]         out_data
);
  import mrx_pkg::*;

  logic [7:0]  max_pdu_data;
  logic [15:0] running_crc;
  logic [15:0] held_bytes;
  logic [7:0]  frame_address;
  logic [7:0]  frame_function;

  logic        emit;
  logic [1:0]  res_kind;
  logic [31:0] res_data;
  logic [15:0] rx_crc;
  logic [7:0]  older;

  assign pop   = !q_empty && (!out_valid || out_ready);
  assign older = held_bytes[15:8];
  assign rx_crc = {held_bytes[7:0], held_bytes[15:8]};  // low byte arrives first

  always_comb begin
    emit     = 1'b0;
    res_kind = RK_DATA;
    res_data = '0;
    unique case (cmd.op)
      OP_BYTE: begin
        if (cmd.pos == POS_DATA) begin
          emit     = 1'b1;
          res_data = {24'h0, older};
        end
      end
      OP_END: begin
        emit = cmd.report;
        if (rx_crc != running_crc) begin
          res_kind = RK_BADCRC;
        end else if (cmd.len > max_pdu_data) begin
          res_kind = RK_TOOBIG;
        end else begin
          res_kind = RK_GOOD;
        end
        res_data = {cmd.len, frame_function, frame_address, 8'h00};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pdu_data <= MAX_PDU_RESET;
    end else if (cfg_we) begin
      max_pdu_data <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= CRC_INIT;
      held_bytes     <= '0;
      frame_address  <= '0;
      frame_function <= '0;
    end else if (pop) begin
      if (cmd.op == OP_END) begin
        running_crc    <= CRC_INIT;
        held_bytes     <= '0;
        frame_address  <= '0;
        frame_function <= '0;
      end else begin
        if (cmd.pos == POS_ADDR) begin
          frame_address <= cmd.data;
        end
        if (cmd.pos == POS_FUNC) begin
          frame_function <= cmd.data;
        end
        if (cmd.pos == POS_HOLD || cmd.pos == POS_DATA) begin
          running_crc <= crc_feed(running_crc, older);
        end
        held_bytes <= {held_bytes[7:0], cmd.data};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_kind <= res_kind;
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/modbus_rtu_frame_receiver.sv =====
// Top level of the Modbus RTU frame receiver with CRC-16 frame check.
// Depends on mrx_pkg, mrx_front, mrx_queue and mrx_back.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+-------------------
//  s_axis   | in  | [7:0] rx_byte                           | [0] kind
//  m_axis   | out | [7:0] data_byte [15:8] slave_address     | [1:0] result_kind
//           |     | [23:16] function_code [31:24] data_length|
//  cfg      | in  | cfg_wdata = max_pdu_data, write on cfg_we|
//
// One request per cycle in while s_axis_tready is high, one result per cycle out while
// m_axis_tready is high; a result passes the queue slot and then the output register.
// The four-entry command queue lets the front keep accepting while the
// output stalls; s_axis_tready drops only when that queue is full.
// Reset (rst, synchronous) clears the frame state and sets max_pdu_data to 252.
`default_nettype none

module modbus_rtu_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // data_byte, slave_address, function_code, data_length
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  import mrx_pkg::*;

  logic   push;
  logic   pop;
  cmd_t   front_cmd;
  cmd_t   head_cmd;
  qstat_t q_stat;

  mrx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser[0]),
    .in_byte  (s_axis_tdata),
    .q_full   (q_stat.full),
    .push     (push),
    .cmd      (front_cmd)
  );

  mrx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  mrx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_stat.empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("command queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  a_status_out: assert property (@(posedge clk) disable iff (rst)
    (pop && head_cmd.op == OP_END && head_cmd.report) |=>
      (m_axis_tvalid && m_axis_tuser != RK_DATA))
    else $error("frame status not presented");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == RK_DATA) |-> (m_axis_tdata[31:8] == 24'h0))
    else $error("data result carries frame fields");

endmodule

`default_nettype wire
